// ----- hdl/jsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared codes, types and helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // decoder modes
   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_BODY = 3'd1;
   localparam logic [2:0] MODE_ESC  = 3'd2;
   localparam logic [2:0] MODE_HEX1 = 3'd3;
   localparam logic [2:0] MODE_BS   = 3'd4;
   localparam logic [2:0] MODE_U    = 3'd5;
   localparam logic [2:0] MODE_HEX2 = 3'd6;
   localparam logic [2:0] MODE_ERR  = 3'd7;

   // error codes
   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_NO_QUOTE  = 4'd1;
   localparam logic [3:0] ERR_CONTROL   = 4'd2;
   localparam logic [3:0] ERR_CUT_ESC   = 4'd3;
   localparam logic [3:0] ERR_BAD_ESC   = 4'd4;
   localparam logic [3:0] ERR_CUT_HEX   = 4'd5;
   localparam logic [3:0] ERR_BAD_HEX   = 4'd6;
   localparam logic [3:0] ERR_LONE_HIGH = 4'd7;
   localparam logic [3:0] ERR_BAD_LOW   = 4'd8;
   localparam logic [3:0] ERR_LONE_LOW  = 4'd9;
   localparam logic [3:0] ERR_UNTERM    = 4'd10;

   // special characters
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_U     = 8'h75;

   // encoded code point: up to four bytes, byte 0 first
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } utf8_type;

   // hex digit: bit 4 set when the character is not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39)      v = {1'b0, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
      else                               v = 5'h10;
      return v;
   endfunction

   // simple escapes: bit 8 set when not a valid escape letter
   function automatic logic [8:0] simple_escape(input logic [7:0] c);
      logic [8:0] v;
      case (c)
         8'h22:   v = 9'h022;
         8'h5c:   v = 9'h05c;
         8'h2f:   v = 9'h02f;
         8'h62:   v = 9'h008;
         8'h66:   v = 9'h00c;
         8'h6e:   v = 9'h00a;
         8'h72:   v = 9'h00d;
         8'h74:   v = 9'h009;
         default: v = 9'h100;
      endcase
      return v;
   endfunction

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type u;
      u.bytes = '0;
      if (cp <= 21'h7f) begin
         u.count    = 3'd1;
         u.bytes[0] = cp[7:0];
      end else if (cp <= 21'h7ff) begin
         u.count    = 3'd2;
         u.bytes[0] = {3'b110, cp[10:6]};
         u.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hffff) begin
         u.count    = 3'd3;
         u.bytes[0] = {4'b1110, cp[15:12]};
         u.bytes[1] = {2'b10, cp[11:6]};
         u.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         u.count    = 3'd4;
         u.bytes[0] = {5'b11110, cp[20:18]};
         u.bytes[1] = {2'b10, cp[17:12]};
         u.bytes[2] = {2'b10, cp[11:6]};
         u.bytes[3] = {2'b10, cp[5:0]};
      end
      return u;
   endfunction

endpackage

// ----- hdl/json_string_unescape_utf8_top.sv -----
`timescale 1ns / 1ps
// An accepted input word is held in the input register, then decoded into the result buffer.
// Throughput: one input word per cycle while each yields one output word and rsp_tready is high;
// an input word that decodes to n UTF-8 bytes (n <= 4) leaves the single output buffer as n words.
// Reset (synchronous, active high): pipeline empty, decoder idle, no error held.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// Decodes a JSON string literal, one raw byte per word, into UTF-8 bytes,
// with simple escapes, \uXXXX escapes, surrogate pairs and sticky errors.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic [1:0]  req_tuser,   // [0] string_start, [1] end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] string_done,
                                    // [12:9] error_code, [15:13] zero
   output logic        rsp_tuser,   // [0] byte_valid
   output logic        rsp_tlast    // last word caused by one input word
);

   // ---------------- input register ----------------
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff, in_eoi_ff;

   // ---------------- decoder state ----------------
   logic [2:0]  mode_ff, mode_in;
   logic [15:0] code_ff, code_in;
   logic [9:0]  high_ff, high_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [3:0]  err_ff, err_in;

   // ---------------- result buffer ----------------
   logic             res_valid_ff, res_valid_in;
   logic [3:0][7:0]  res_bytes_ff;
   logic [2:0]       res_cnt_ff;
   logic [1:0]       res_idx_ff, res_idx_in;
   logic             res_bv_ff;
   logic             res_done_ff;
   logic [3:0]       res_err_ff;

   // decode outputs
   logic [3:0][7:0]  dec_bytes;
   logic [2:0]       dec_cnt;
   logic             dec_done;

   logic req_fire, rsp_fire, rsp_last, res_free, advance;

   logic [4:0]  hex_d;
   logic [8:0]  esc_v;
   logic [15:0] cu_new;
   logic [20:0] pair_cp;
   jsu_pkg::utf8_type enc;

   // handshake and flow: the decode step fires when the input register holds a word
   // and the buffer is empty or is handing out its final word in this cycle
   assign rsp_last = (res_idx_ff == 2'(res_cnt_ff - 3'd1));
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign res_free = !res_valid_ff || (rsp_tready && rsp_last);
   assign advance  = in_valid_ff && res_free;
   assign req_tready = !in_valid_ff || res_free;
   assign req_fire = req_tvalid && req_tready;

   assign rsp_tvalid = res_valid_ff;
   assign rsp_tdata  = {3'b000, res_err_ff, res_done_ff, res_bytes_ff[res_idx_ff]};
   assign rsp_tuser  = res_bv_ff;
   assign rsp_tlast  = rsp_last;

   // hex and escape lookups on the registered byte
   assign hex_d   = jsu_pkg::hex_value(in_byte_ff);
   assign esc_v   = jsu_pkg::simple_escape(in_byte_ff);
   assign cu_new  = {code_ff[11:0], hex_d[3:0]};
   // 0x10000 + (high << 10) + (low - 0xdc00)
   assign pair_cp = 21'h10000 + {1'b0, high_ff, cu_new[9:0]};

   // one encoder, fed by the BMP code unit or the joined pair
   always_comb begin
      if (mode_ff == jsu_pkg::MODE_HEX2) enc = jsu_pkg::utf8_encode(pair_cp);
      else                               enc = jsu_pkg::utf8_encode({5'b0, cu_new});
   end

   // decode step
   always_comb begin
      mode_in   = mode_ff;
      code_in   = code_ff;
      high_in   = high_ff;
      cnt_in    = cnt_ff;
      err_in    = err_ff;
      dec_bytes = '0;
      dec_cnt   = 3'd0;
      dec_done  = 1'b0;

      if (in_start_ff) begin
         // a new string always starts over
         code_in = '0;
         high_in = '0;
         cnt_in  = '0;
         if (in_eoi_ff || in_byte_ff != jsu_pkg::CH_QUOTE) begin
            mode_in = jsu_pkg::MODE_ERR;
            err_in  = jsu_pkg::ERR_NO_QUOTE;
         end else begin
            mode_in = jsu_pkg::MODE_BODY;
            err_in  = jsu_pkg::ERR_NONE;
         end
      end else if (in_eoi_ff) begin
         case (mode_ff)
            jsu_pkg::MODE_BODY: err_in = jsu_pkg::ERR_UNTERM;
            jsu_pkg::MODE_ESC:  err_in = jsu_pkg::ERR_CUT_ESC;
            jsu_pkg::MODE_HEX1,
            jsu_pkg::MODE_HEX2: err_in = jsu_pkg::ERR_CUT_HEX;
            jsu_pkg::MODE_BS,
            jsu_pkg::MODE_U:    err_in = jsu_pkg::ERR_LONE_HIGH;
            default:            err_in = err_ff;
         endcase
         if (mode_ff != jsu_pkg::MODE_IDLE && mode_ff != jsu_pkg::MODE_ERR) begin
            mode_in = jsu_pkg::MODE_ERR;
            code_in = '0;
            high_in = '0;
            cnt_in  = '0;
         end
      end else begin
         case (mode_ff)
            jsu_pkg::MODE_BODY: begin
               if (in_byte_ff == jsu_pkg::CH_QUOTE) begin
                  dec_done = 1'b1;
                  mode_in  = jsu_pkg::MODE_IDLE;
                  code_in  = '0;
                  high_in  = '0;
                  cnt_in   = '0;
               end else if (in_byte_ff < 8'h20) begin
                  mode_in = jsu_pkg::MODE_ERR;
                  err_in  = jsu_pkg::ERR_CONTROL;
                  code_in = '0;
                  high_in = '0;
                  cnt_in  = '0;
               end else if (in_byte_ff == jsu_pkg::CH_BSLASH) begin
                  mode_in = jsu_pkg::MODE_ESC;
               end else begin
                  dec_bytes[0] = in_byte_ff;
                  dec_cnt      = 3'd1;
               end
            end
            jsu_pkg::MODE_ESC: begin
               if (in_byte_ff == jsu_pkg::CH_U) begin
                  mode_in = jsu_pkg::MODE_HEX1;
                  code_in = '0;
                  cnt_in  = '0;
               end else if (esc_v[8]) begin
                  mode_in = jsu_pkg::MODE_ERR;
                  err_in  = jsu_pkg::ERR_BAD_ESC;
                  code_in = '0;
                  high_in = '0;
                  cnt_in  = '0;
               end else begin
                  dec_bytes[0] = esc_v[7:0];
                  dec_cnt      = 3'd1;
                  mode_in      = jsu_pkg::MODE_BODY;
               end
            end
            jsu_pkg::MODE_HEX1,
            jsu_pkg::MODE_HEX2: begin
               if (hex_d[4]) begin
                  mode_in = jsu_pkg::MODE_ERR;
                  err_in  = jsu_pkg::ERR_BAD_HEX;
                  code_in = '0;
                  high_in = '0;
                  cnt_in  = '0;
               end else if (cnt_ff != 2'd3) begin
                  code_in = cu_new;
                  cnt_in  = 2'(cnt_ff + 2'd1);
               end else begin
                  cnt_in = '0;
                  if (mode_ff == jsu_pkg::MODE_HEX1) begin
                     if (cu_new[15:10] == 6'b110110) begin
                        // high surrogate: wait for the low half
                        high_in = cu_new[9:0];
                        code_in = '0;
                        mode_in = jsu_pkg::MODE_BS;
                     end else if (cu_new[15:10] == 6'b110111) begin
                        mode_in = jsu_pkg::MODE_ERR;
                        err_in  = jsu_pkg::ERR_LONE_LOW;
                        code_in = '0;
                        high_in = '0;
                     end else begin
                        dec_bytes = enc.bytes;
                        dec_cnt   = enc.count;
                        code_in   = '0;
                        mode_in   = jsu_pkg::MODE_BODY;
                     end
                  end else begin
                     if (cu_new[15:10] != 6'b110111) begin
                        mode_in = jsu_pkg::MODE_ERR;
                        err_in  = jsu_pkg::ERR_BAD_LOW;
                        code_in = '0;
                        high_in = '0;
                     end else begin
                        dec_bytes = enc.bytes;
                        dec_cnt   = enc.count;
                        code_in   = '0;
                        high_in   = '0;
                        mode_in   = jsu_pkg::MODE_BODY;
                     end
                  end
               end
            end
            jsu_pkg::MODE_BS: begin
               if (in_byte_ff == jsu_pkg::CH_BSLASH) begin
                  mode_in = jsu_pkg::MODE_U;
               end else begin
                  mode_in = jsu_pkg::MODE_ERR;
                  err_in  = jsu_pkg::ERR_LONE_HIGH;
                  code_in = '0;
                  high_in = '0;
                  cnt_in  = '0;
               end
            end
            jsu_pkg::MODE_U: begin
               if (in_byte_ff == jsu_pkg::CH_U) begin
                  mode_in = jsu_pkg::MODE_HEX2;
                  code_in = '0;
                  cnt_in  = '0;
               end else begin
                  mode_in = jsu_pkg::MODE_ERR;
                  err_in  = jsu_pkg::ERR_LONE_HIGH;
                  code_in = '0;
                  high_in = '0;
                  cnt_in  = '0;
               end
            end
            default: begin
               // idle or error: byte ignored
            end
         endcase
      end
   end

   // next values for the stage valids and output index
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      res_valid_in = res_valid_ff;
      res_idx_in   = res_idx_ff;
      if (advance) begin
         res_valid_in = 1'b1;
         res_idx_in   = '0;
      end else if (rsp_fire) begin
         if (rsp_last) res_valid_in = 1'b0;
         else          res_idx_in   = 2'(res_idx_ff + 2'd1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
         res_idx_ff   <= '0;
         mode_ff      <= jsu_pkg::MODE_IDLE;
         code_ff      <= '0;
         high_ff      <= '0;
         cnt_ff       <= '0;
         err_ff       <= jsu_pkg::ERR_NONE;
      end else begin
         in_valid_ff  <= in_valid_in;
         res_valid_ff <= res_valid_in;
         res_idx_ff   <= res_idx_in;
         if (advance) begin
            mode_ff <= mode_in;
            code_ff <= code_in;
            high_ff <= high_in;
            cnt_ff  <= cnt_in;
            err_ff  <= err_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser[0];
         in_eoi_ff   <= req_tuser[1];
      end
      if (advance) begin
         res_bytes_ff <= dec_bytes;
         // a step with no decoded byte still yields one status word
         res_cnt_ff   <= (dec_cnt == 3'd0) ? 3'd1 : dec_cnt;
         res_bv_ff    <= (dec_cnt != 3'd0);
         res_done_ff  <= dec_done;
         res_err_ff   <= (mode_in == jsu_pkg::MODE_ERR) ? err_in : jsu_pkg::ERR_NONE;
      end
   end

endmodule
